// ===== src/lpm_pkg.sv =====
// Shared types and constants for the linear partition min-max-sum block.
// No dependencies; imported by every module of the block but lpm_store.
`default_nettype none

package lpm_pkg;

    localparam int VALUE_W = 16;   // width of one sequence value
    localparam int OUT_W   = 26;   // width of bound and segment sum on the result channel
    localparam int PARTS_W = 7;    // width of the parts register

    localparam logic [PARTS_W-1:0] PART_CAP   = PARTS_W'(64);
    localparam logic [PARTS_W-1:0] PARTS_ONE  = PARTS_W'(1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SEARCH,
        S_PROBE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [OUT_W-1:0] best_max;
        logic [OUT_W-1:0] segment_sum;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

// ===== src/lpm_store.sv =====
// Value store: one write port, one read port, read data registered.
// Depends on nothing; instantiated by lpm_ctrl.
`default_nettype none

module lpm_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/lpm_ctrl.sv =====
// Load, bound search and segment walk for the partition block.
// Depends on lpm_pkg; instantiates lpm_store.
`default_nettype none

module lpm_ctrl
    import lpm_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [PARTS_W-1:0] i_parts,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [VALUE_W-1:0] i_item_value,
    input  wire logic               i_last_item,
    output logic                    o_push,
    output t_result                 o_result,
    input  wire logic               i_push_ready
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = (VALUE_W + AW > OUT_W) ? VALUE_W + AW : OUT_W;
    localparam int CW    = (CNT_W > PARTS_W) ? CNT_W : PARTS_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_walk, n_walk;
    logic [CNT_W-1:0] r_groups, n_groups;
    logic [CNT_W-1:0] r_want, n_want;
    logic [CNT_W-1:0] r_need, n_need;
    logic [SUM_W-1:0] r_total, n_total;
    logic [SUM_W-1:0] r_low, n_low;
    logic [SUM_W-1:0] r_high, n_high;
    logic [SUM_W-1:0] r_mid, n_mid;
    logic [SUM_W-1:0] r_acc, n_acc;

    logic [VALUE_W-1:0] rd_data;
    logic               wr_en;
    logic               in_acc;
    logic               at_end;
    logic               probe_fail;
    logic               take;
    logic               close_last;
    logic [SUM_W-1:0]   v_ext;
    logic [SUM_W:0]     mid_sum;
    logic [SUM_W:0]     acc_add;
    logic [CNT_W:0]     walk_need;
    logic [CNT_W-1:0]   need_dec;
    logic [CW-1:0]      parts_c;
    logic [CW-1:0]      cnt_ext;
    logic [CW-1:0]      want_c;

    lpm_store #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_item_value),
        .i_rd_addr (n_walk[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // The read address follows n_walk every cycle, so rd_data is always mem[r_walk].
    assign v_ext      = SUM_W'(rd_data);
    assign in_acc     = i_in_valid && (r_state == S_LOAD);
    assign wr_en      = in_acc && (r_count < MAX_CNT);
    assign o_in_stall = (r_state != S_LOAD);
    assign at_end     = (r_walk >= r_count);
    assign mid_sum    = {1'b0, r_low} + {1'b0, r_high};
    assign acc_add    = {1'b0, r_acc} + {1'b0, v_ext};
    assign probe_fail = !at_end && (v_ext > r_mid);
    assign walk_need  = {1'b0, r_walk} + {1'b0, r_need};
    assign need_dec   = r_need - CNT_W'(1);

    // Extend the segment while the value fits and one item stays for each later part.
    assign take = !at_end && (acc_add <= {1'b0, r_low}) && (walk_need <= {1'b0, r_count});

    assign close_last = (need_dec == '0) || at_end ||
                        ((r_acc == '0) && (need_dec != '0) && (v_ext > r_low));

    assign o_push   = (r_state == S_EMIT) && !take;
    assign o_result = '{best_max:    r_low[OUT_W-1:0],
                        segment_sum: r_acc[OUT_W-1:0],
                        last:        close_last};

    // Clamp parts to 1..64, then to the item count.
    always_comb begin
        if (i_parts == '0) begin
            parts_c = CW'(PARTS_ONE);
        end else if (i_parts > PART_CAP) begin
            parts_c = CW'(PART_CAP);
        end else begin
            parts_c = CW'(i_parts);
        end
        cnt_ext = CW'(r_count);
        want_c  = (parts_c > cnt_ext) ? cnt_ext : parts_c;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && i_last_item) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_state = (r_low < r_high) ? S_PROBE : S_EMIT;
            end
            S_PROBE: begin
                if (at_end || probe_fail) begin
                    n_state = S_SEARCH;
                end
            end
            S_EMIT: begin
                if (o_push && i_push_ready && close_last) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_total  = r_total;
        n_walk   = r_walk;
        n_groups = r_groups;
        n_want   = r_want;
        n_need   = r_need;
        n_low    = r_low;
        n_high   = r_high;
        n_mid    = r_mid;
        n_acc    = r_acc;
        unique case (r_state)
            S_LOAD: begin
                if (wr_en) begin
                    n_count = r_count + CNT_W'(1);
                    n_total = r_total + SUM_W'(i_item_value);
                end
            end
            S_START: begin
                n_low  = SUM_W'(1);
                n_high = (r_total > SUM_W'(1)) ? r_total : SUM_W'(1);
                n_want = want_c[CNT_W-1:0];
            end
            S_SEARCH: begin
                n_mid    = mid_sum[SUM_W:1];
                n_walk   = '0;
                n_acc    = '0;
                n_groups = CNT_W'(1);
                n_need   = r_want;
            end
            S_PROBE: begin
                if (at_end) begin
                    if (r_groups <= r_want) begin
                        n_high = r_mid;
                    end else begin
                        n_low = r_mid + SUM_W'(1);
                    end
                end else if (probe_fail) begin
                    n_low = r_mid + SUM_W'(1);
                end else begin
                    n_walk = r_walk + CNT_W'(1);
                    if (acc_add <= {1'b0, r_mid}) begin
                        n_acc = acc_add[SUM_W-1:0];
                    end else begin
                        n_groups = r_groups + CNT_W'(1);
                        n_acc    = v_ext;
                    end
                end
            end
            S_EMIT: begin
                if (take) begin
                    n_acc  = acc_add[SUM_W-1:0];
                    n_walk = r_walk + CNT_W'(1);
                end else if (i_push_ready) begin
                    n_need = need_dec;
                    n_acc  = '0;
                    if (close_last) begin
                        n_count = '0;
                        n_total = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk   <= n_walk;
        r_groups <= n_groups;
        r_want   <= n_want;
        r_need   <= n_need;
        r_low    <= n_low;
        r_high   <= n_high;
        r_mid    <= n_mid;
        r_acc    <= n_acc;
    end

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_low <= r_high) && (r_low != '0))
        else $error("search bounds crossed");

    a_probe_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_walk <= r_count))
        else $error("probe walked past item count");

    a_push_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_need != '0) && (r_acc <= r_low))
        else $error("segment pushed with no part left or above bound");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_push_ready && o_result.last) |=> (r_state == S_LOAD) && (r_count == '0))
        else $error("final beat did not return to load");

endmodule

`default_nettype wire

// ===== src/lpm_outq.sv =====
// Output register for result beats; holds one beat so the walk stalls only while it is full and the receiver stalls.
// Depends on lpm_pkg.
`default_nettype none

module lpm_outq
    import lpm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && o_ready) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the beat while stalled.
    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_data <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/linear_partition_min_max_sum_top.sv =====
// Linear partition block: splits a loaded sequence into at most `parts` contiguous
// segments minimizing the largest segment sum, and streams the segment sums.
// Depends on lpm_pkg, lpm_ctrl, lpm_store and lpm_outq.
//
// Input channel: one value per beat (i_item_value), i_last_item closes the sequence.
// Values load at one beat per cycle into the value store; beats past MAX_ITEMS are
// dropped from the store but a last flag on them still closes the sequence.
// After the last beat o_in_stall stays high while the block searches the bound and
// walks the segments. The search runs about log2(total) probes, each one pass over
// the store (N items, one store read per cycle) that ends early when a value exceeds
// the probe bound; the segment walk then makes one more pass over the store. The single
// read port of the value store sets this pace.
// Output channel: one beat per segment with the bound, the segment sum and a last
// flag on the final beat. A one-entry output register holds a beat while the
// receiver stalls; the walk pauses until the beat can move on.
// Configuration: i_cfg_wr_en writes the parts register; write it only between
// sequences. Reset sets parts to 1 and empties the sequence; the store is not cleared.
`default_nettype none

module linear_partition_min_max_sum_top
    import lpm_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [PARTS_W-1:0] i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [VALUE_W-1:0] i_item_value,
    input  wire logic               i_last_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [OUT_W-1:0]        o_best_max,
    output logic [OUT_W-1:0]        o_segment_sum,
    output logic                    o_last
);

    logic [PARTS_W-1:0] r_parts;
    logic               push;
    logic               push_ready;
    t_result            push_result;
    t_result            out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts <= PARTS_ONE;
        end else if (i_cfg_wr_en) begin
            r_parts <= i_cfg_wr_data;
        end
    end

    lpm_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_parts      (r_parts),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item_value (i_item_value),
        .i_last_item  (i_last_item),
        .o_push       (push),
        .o_result     (push_result),
        .i_push_ready (push_ready)
    );

    lpm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (push_result),
        .o_ready     (push_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_best_max    = out_result.best_max;
    assign o_segment_sum = out_result.segment_sum;
    assign o_last        = out_result.last;

endmodule

`default_nettype wire

// ===== verif/lpm_segment_checker.sv =====
// Checker for the linear partition block: predicts the segment sums of every
// sequence and compares them with the result beats. Depends on lpm_pkg.
// Watches the configuration, input and result channels; reports a mismatch count.

module lpm_segment_checker
    import lpm_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [PARTS_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [VALUE_W-1:0] i_item_value,
    input  logic               i_last_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [OUT_W-1:0]   i_best_max,
    input  logic [OUT_W-1:0]   i_segment_sum,
    input  logic               i_last,
    output int                 o_mismatch_count,
    output int                 o_pending
);

    logic [PARTS_W-1:0] parts_reg;
    logic [VALUE_W-1:0] seq_values [MAX_ITEMS];
    int                 seq_len;
    logic [OUT_W:0]     seq_total;
    t_result            expected_segments [$];

    task automatic note_mismatch(input string msg);
        o_mismatch_count++;
        if (o_mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Greedy split under a bound: does it need no more than want groups?
    function automatic bit bound_fits(input logic [OUT_W:0] bound, input int want);
        int             groups;
        logic [OUT_W:0] acc;
        groups = 1;
        acc    = '0;
        for (int i = 0; i < seq_len; i++) begin
            if (seq_values[i] > bound)
                return 1'b0;
            if (acc + seq_values[i] <= bound) begin
                acc = acc + seq_values[i];
            end else begin
                groups++;
                acc = seq_values[i];
            end
        end
        return groups <= want;
    endfunction

    task automatic predict_segments();
        int             want;
        int             need;
        int             walk;
        int             produced;
        logic [OUT_W:0] lo;
        logic [OUT_W:0] hi;
        logic [OUT_W:0] mid;
        logic [OUT_W:0] seg;
        t_result        held;
        want = (parts_reg == '0) ? 1 : int'(parts_reg);
        if (want > int'(PART_CAP))
            want = int'(PART_CAP);
        if (want > seq_len)
            want = seq_len;

        lo = 1;
        hi = (seq_total > 1) ? seq_total : 1;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (bound_fits(mid, want))
                hi = mid;
            else
                lo = mid + 1;
        end

        // Walk again; close a segment early to leave one item per remaining part.
        need     = want;
        walk     = 0;
        produced = 0;
        while (walk < seq_len && need > 0 && produced < int'(PART_CAP)) begin
            seg = '0;
            while (walk < seq_len && seg + seq_values[walk] <= lo &&
                   need - 1 <= seq_len - 1 - walk) begin
                seg = seg + seq_values[walk];
                walk++;
            end
            need--;
            if (produced > 0)
                expected_segments.push_back(held);
            held.best_max    = lo[OUT_W-1:0];
            held.segment_sum = seg[OUT_W-1:0];
            held.last        = (need == 0 || walk >= seq_len);
            produced++;
            if (seg == 0 && walk < seq_len && need > 0 && seq_values[walk] > lo)
                break;
        end
        held.last = 1'b1;
        expected_segments.push_back(held);
    endtask

    task automatic check_segment();
        t_result got;
        t_result exp_seg;
        got = '{best_max: i_best_max, segment_sum: i_segment_sum, last: i_last};
        if (expected_segments.size() == 0) begin
            note_mismatch($sformatf("unexpected result beat: best_max=%0d sum=%0d last=%0b",
                                    got.best_max, got.segment_sum, got.last));
        end else begin
            exp_seg = expected_segments.pop_front();
            if (got.best_max !== exp_seg.best_max ||
                got.segment_sum !== exp_seg.segment_sum ||
                got.last !== exp_seg.last)
                note_mismatch($sformatf(
                    "result mismatch: expected best_max=%0d sum=%0d last=%0b, got best_max=%0d sum=%0d last=%0b",
                    exp_seg.best_max, exp_seg.segment_sum, exp_seg.last,
                    got.best_max, got.segment_sum, got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parts_reg = PARTS_ONE;
            seq_len   = 0;
            seq_total = '0;
            expected_segments.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_segment();
            if (i_cfg_wr_en)
                parts_reg = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                // drop values once the store is full
                if (seq_len < MAX_ITEMS) begin
                    seq_values[seq_len] = i_item_value;
                    seq_len++;
                    seq_total = seq_total + i_item_value;
                end
                if (i_last_item) begin
                    predict_segments();
                    seq_len   = 0;
                    seq_total = '0;
                end
            end
        end
        o_pending = expected_segments.size();
    end

endmodule

// ===== verif/linear_partition_min_max_sum_top_tb.sv =====
// Testbench top for the linear partition block: clock, reset, stimulus and verdict.
// Depends on lpm_pkg, linear_partition_min_max_sum_top and lpm_segment_checker.

module linear_partition_min_max_sum_top_tb;
    import lpm_pkg::*;

    localparam int MAX_ITEMS       = 1024;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASE_ITEMS     = 12;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [PARTS_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] item_value  = '0;
    logic               last_item   = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [OUT_W-1:0]   best_max;
    logic [OUT_W-1:0]   segment_sum;
    logic               seg_last;

    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_off  = 1'b0;
    int   mismatch_count;
    int   pending;
    int   cycle_count;

    linear_partition_min_max_sum_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_item_value  (item_value),
        .i_last_item   (last_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_best_max    (best_max),
        .o_segment_sum (segment_sum),
        .o_last        (seg_last)
    );

    lpm_segment_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_item_value     (item_value),
        .i_last_item      (last_item),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_best_max       (best_max),
        .i_segment_sum    (segment_sum),
        .i_last           (seg_last),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // Enter and leave at a falling edge; valid stays up for the caller to reuse or drop.
    task automatic push_item(input logic [VALUE_W-1:0] v, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        item_value <= v;
        last_item  <= l;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_W'($urandom_range(15));
            4:       return VALUE_W'($urandom_range(16'h0400));
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    task automatic push_random_sequence(input int len);
        for (int i = 0; i < len; i++)
            push_item(pick_value(), i == len - 1);
    endtask

    // Drop valid, wait for every expected beat, then let the walk settle.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_parts(input logic [PARTS_W-1:0] p);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int                 sent;
        int                 len;
        logic [PARTS_W-1:0] parts_pick;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // parts at its reset value of one
        push_item('1, 1'b0);
        push_item('0, 1'b0);
        push_item(VALUE_W'(1), 1'b1);
        // all-zero sequence: bound floors at one
        push_item('0, 1'b1);
        push_item('1, 1'b1);

        // zero parts acts as one
        write_parts('0);
        push_item(VALUE_W'(7), 1'b0);
        push_item(VALUE_W'(9), 1'b1);

        // saturate to the cap, and fewer items than parts
        write_parts('1);
        push_item(VALUE_W'(5), 1'b0);
        push_item('0, 1'b0);
        push_item(VALUE_W'(3), 1'b1);

        write_parts(PART_CAP);
        push_item('1, 1'b0);
        push_item('1, 1'b0);
        push_item(VALUE_W'(1), 1'b0);
        push_item('1, 1'b1);

        write_parts(PARTS_W'(3));
        repeat (4) push_item('0, 1'b0);
        push_item('0, 1'b1);

        write_parts(PARTS_W'(2));
        push_item(16'hAAAA, 1'b0);
        push_item(16'h5555, 1'b0);
        push_item(VALUE_W'(1), 1'b0);
        push_item(VALUE_W'(2), 1'b0);
        push_item(VALUE_W'(3), 1'b1);

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default: begin
                    idle_pct  = 16;
                    stall_pct = 16;
                end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                case ($urandom_range(6))
                    0:       parts_pick = '0;
                    1:       parts_pick = '1;
                    2:       parts_pick = PART_CAP;
                    3:       parts_pick = PARTS_ONE;
                    4:       parts_pick = PARTS_W'($urandom_range(65, 126));
                    5:       parts_pick = PARTS_W'($urandom_range(13, 63));
                    default: parts_pick = PARTS_W'($urandom_range(2, 12));
                endcase
                write_parts(parts_pick);
                // hold the receiver off so the block backs up into its input
                if (mode == 2 && sub == 0) begin
                    fork
                        begin
                            hold_off <= 1'b1;
                            repeat (HOLD_OFF_CYCLES) @(negedge clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                end
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(17, 80)
                                                   : $urandom_range(1, 16);
                    push_random_sequence(len);
                    sent += len;
                end
            end
        end

        drain_block();
        if (mismatch_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lpm_pkg.sv
src/lpm_store.sv
src/lpm_ctrl.sv
src/lpm_outq.sv
src/linear_partition_min_max_sum_top.sv
verif/lpm_segment_checker.sv
verif/linear_partition_min_max_sum_top_tb.sv
